[design/zpwm_pkg.sv]
`default_nettype none
package zpwm_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int WIN_SIDE      = 5;
  localparam int FW_W          = 11;
  localparam int FH_W          = 13;
  localparam logic [FW_W-1:0] FW_RST = 11'd1024;
  localparam logic [FH_W-1:0] FH_RST = 13'd768;
  localparam int CH            = 3;
  localparam int PIX_W         = 24;
  localparam int SUM_W         = 13;  // 25 * 255 fits
  localparam int CNT_W         = 5;   // up to 25 contributors
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  // register indexes on the config port
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    logic       flush;
  } in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       frame_end;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_TAIL,
    ST_DIVS,
    ST_DIVW,
    ST_EMIT
  } state_t;

  typedef logic [CH-1:0][SUM_W-1:0] sums_t;
  typedef logic [CH-1:0][CNT_W-1:0] cnts_t;
  typedef logic [CH-1:0][7:0]       quos_t;

endpackage
`default_nettype wire

[design/zero_pixel_window_mean_fill.sv]
`default_nettype none
// Zero-pixel repair over a 5x5 window clipped to the frame. Pixels arrive in
// raster order; a channel value of zero marks it damaged and is replaced by
// the floor mean of the nonzero values of that channel in the window (zero
// if there are none). Output lags input by 2*W+2 pixels (W = frame width);
// after the last pixel of a frame, send flush transactions to drain. Pixel
// history sits in one single-port-read history RAM of 4*MAX_WIDTH+5 words.
// A pixel that causes no output is taken and done with; one that causes
// an output goes through the accepting state, setup, 25 window reads from
// the RAM (one per cycle), a tail state, a divider start state, 13 divide
// steps plus a done strobe, and an emit into the output register, which
// stretches while an earlier result still waits there.
// The next transaction is taken while a result waits in the output
// register. Config writes are taken only when the block holds no pixel and
// no frame is partly received; otherwise ignored.
module zero_pixel_window_mean_fill #(
  parameter int MAX_WIDTH = zpwm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire zpwm_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output zpwm_pkg::out_t                      out_data,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [zpwm_pkg::APB_AW-1:0]    cfg_paddr,
  input  wire logic [zpwm_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic      [zpwm_pkg::APB_DW-1:0]    cfg_prdata,
  output logic                                cfg_pready
);

  localparam int D  = 4 * MAX_WIDTH + 5;       // history depth
  localparam int AW = $clog2(D);
  localparam int WW = $clog2(MAX_WIDTH + 1);   // effective width
  localparam int PW = $clog2(2 * MAX_WIDTH + 4); // pending count
  localparam int HW = zpwm_pkg::FH_W;
  localparam int CW = PW + 2;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
    wrap = (v >= (AW+1)'(D)) ? AW'(v - (AW+1)'(D)) : AW'(v);
  endfunction

  // ---- config registers ----
  logic [zpwm_pkg::FW_W-1:0] fw_r;
  logic [zpwm_pkg::FH_W-1:0] fh_r;
  logic [WW-1:0]             w_eff;
  logic [HW-1:0]             h_eff;

  // ---- control state ----
  zpwm_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] wr_r;
  logic [PW-1:0] pend_r;
  logic [WW-1:0] in_col_r;
  logic [HW-1:0] in_row_r;
  logic [WW-1:0] out_col_r;
  logic [HW-1:0] out_row_r;
  logic [AW-1:0] ci_r;
  logic [AW-1:0] rbase_r;
  logic [2:0]    dr_r, dc_r;
  logic          rd_v_r, rd_c_r;
  logic          out_valid_r;
  zpwm_pkg::out_t out_data_r;

  // ---- datapath ----
  zpwm_pkg::sums_t sum_r;
  zpwm_pkg::cnts_t cnt_r;
  logic [zpwm_pkg::PIX_W-1:0] ctr_r;
  logic [zpwm_pkg::PIX_W-1:0] rdata;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic          div_start, div_done;
  zpwm_pkg::quos_t quo;

  logic            acc;
  logic            idle;
  logic [PW-1:0]   pend_new;
  logic [AW-1:0]   wr_after;
  logic            emit_go;
  logic [AW-1:0]   ci_calc;
  logic signed [15:0] rpos, cpos;
  logic            win_in;
  logic            out_free;
  logic            cfg_wr;

  always_comb begin
    if (fw_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_r);
    end
    h_eff = (fh_r == '0) ? HW'(1) : fh_r;
  end

  // ---- APB ----
  assign cfg_pready = 1'b1;
  assign idle   = (pend_r == '0) && (in_col_r == '0) && (in_row_r == '0);
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= zpwm_pkg::FW_RST;
      fh_r <= zpwm_pkg::FH_RST;
    end else if (cfg_wr && idle) begin
      case (cfg_paddr[2])
        zpwm_pkg::REG_FRAME_WIDTH:  fw_r <= cfg_pwdata[zpwm_pkg::FW_W-1:0];
        zpwm_pkg::REG_FRAME_HEIGHT: fh_r <= cfg_pwdata[zpwm_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      zpwm_pkg::REG_FRAME_WIDTH:
        cfg_prdata = {{(zpwm_pkg::APB_DW - zpwm_pkg::FW_W){1'b0}}, fw_r};
      zpwm_pkg::REG_FRAME_HEIGHT:
        cfg_prdata = {{(zpwm_pkg::APB_DW - zpwm_pkg::FH_W){1'b0}}, fh_r};
      default: cfg_prdata = '0;
    endcase
  end

  // ---- input side ----
  assign in_ready = (state_r == zpwm_pkg::ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign mem_we   = acc && !in_data.flush;
  assign pend_new = in_data.flush ? pend_r : pend_r + 1'b1;
  assign wr_after = in_data.flush ? wr_r : wrap({1'b0, wr_r} + 1'b1);
  // centre pixel = wr_after - pend_new (mod D)
  assign ci_calc  = wrap({1'b0, wr_after} + (AW+1)'(D) - (AW+1)'(pend_new));

  always_comb begin
    if (!in_data.flush) begin
      emit_go = CW'(pend_new) > (CW'(w_eff) * CW'(2) + CW'(2));
    end else begin
      emit_go = (in_col_r == '0) && (in_row_r == '0) && (pend_r != '0);
    end
  end

  // ---- window walk: clip test for the address being issued ----
  assign rpos   = 16'(out_row_r) + 16'(dr_r) - 16'sd2;
  assign cpos   = 16'(out_col_r) + 16'(dc_r) - 16'sd2;
  assign win_in = (rpos >= 0) && (rpos < $signed(16'(h_eff))) &&
                  (cpos >= 0) && (cpos < $signed(16'(w_eff)));
  assign raddr  = wrap({1'b0, rbase_r} + (AW+1)'(dc_r));

  assign out_free  = !out_valid_r || out_ready;
  assign div_start = (state_r == zpwm_pkg::ST_DIVS);

  // ---- FSM ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      zpwm_pkg::ST_IDLE:  if (acc && emit_go) state_nxt = zpwm_pkg::ST_SETUP;
      zpwm_pkg::ST_SETUP: state_nxt = zpwm_pkg::ST_READ;
      zpwm_pkg::ST_READ: begin
        if (dr_r == 3'd4 && dc_r == 3'd4) state_nxt = zpwm_pkg::ST_TAIL;
      end
      zpwm_pkg::ST_TAIL:  state_nxt = zpwm_pkg::ST_DIVS;
      zpwm_pkg::ST_DIVS:  state_nxt = zpwm_pkg::ST_DIVW;
      zpwm_pkg::ST_DIVW:  if (div_done) state_nxt = zpwm_pkg::ST_EMIT;
      zpwm_pkg::ST_EMIT:  if (out_free) state_nxt = zpwm_pkg::ST_IDLE;
      default:            state_nxt = zpwm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zpwm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // position counters, pointers, pending count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r      <= '0;
      pend_r    <= '0;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      if (mem_we) begin
        wr_r   <= wr_after;
        pend_r <= pend_new;
        if (in_col_r + 1'b1 >= w_eff) begin
          in_col_r <= '0;
          in_row_r <= (in_row_r + 1'b1 >= h_eff) ? '0 : in_row_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
      end
      if (state_r == zpwm_pkg::ST_EMIT && out_free) begin
        pend_r <= pend_r - 1'b1;
        if (out_col_r + 1'b1 >= w_eff) begin
          out_col_r <= '0;
          out_row_r <= (out_row_r + 1'b1 >= h_eff) ? '0 : out_row_r + 1'b1;
        end else begin
          out_col_r <= out_col_r + 1'b1;
        end
      end
    end
  end

  // walk counters and read tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      rd_c_r <= 1'b0;
      dr_r   <= '0;
      dc_r   <= '0;
    end else begin
      rd_v_r <= (state_r == zpwm_pkg::ST_READ) && win_in;
      rd_c_r <= (state_r == zpwm_pkg::ST_READ) && dr_r == 3'd2 && dc_r == 3'd2;
      if (state_r == zpwm_pkg::ST_SETUP) begin
        dr_r <= '0;
        dc_r <= '0;
      end else if (state_r == zpwm_pkg::ST_READ) begin
        if (dc_r == 3'd4) begin
          dc_r <= '0;
          dr_r <= dr_r + 1'b1;
        end else begin
          dc_r <= dc_r + 1'b1;
        end
      end
    end
  end

  // address bases, accumulation (payload, no reset)
  always_ff @(posedge clk) begin
    if (acc) begin
      ci_r <= ci_calc;
    end
    if (state_r == zpwm_pkg::ST_SETUP) begin
      // top-left of window: centre - (2W+2)
      rbase_r <= wrap({1'b0, ci_r} + (AW+1)'(D) - (AW+1)'(w_eff) * (AW+1)'(2)
                      - (AW+1)'(2));
      sum_r   <= '0;
      cnt_r   <= '0;
      ctr_r   <= '0;
    end else begin
      if (state_r == zpwm_pkg::ST_READ && dc_r == 3'd4) begin
        rbase_r <= wrap({1'b0, rbase_r} + (AW+1)'(w_eff));
      end
      if (rd_v_r) begin
        for (int k = 0; k < zpwm_pkg::CH; k++) begin
          if (rdata[8*k +: 8] != 8'd0) begin
            sum_r[k] <= sum_r[k] + zpwm_pkg::SUM_W'(rdata[8*k +: 8]);
            cnt_r[k] <= cnt_r[k] + 1'b1;
          end
        end
        if (rd_c_r) begin
          ctr_r <= rdata;
        end
      end
    end
  end

  zpwm_hist_mem #(
    .DEPTH (D),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_r),
    .wdata ({in_data.red_in, in_data.green_in, in_data.blue_in}),
    .raddr (raddr),
    .rdata (rdata)
  );

  zpwm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_r),
    .den   (cnt_r),
    .done  (div_done),
    .quo   (quo)
  );

  // ---- output register ----
  logic [zpwm_pkg::CH-1:0][7:0] fix;
  always_comb begin
    for (int k = 0; k < zpwm_pkg::CH; k++) begin
      if (ctr_r[8*k +: 8] == 8'd0 && cnt_r[k] != '0) begin
        fix[k] = quo[k];
      end else begin
        fix[k] = ctr_r[8*k +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == zpwm_pkg::ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == zpwm_pkg::ST_EMIT && out_free) begin
      out_data_r.blue_out  <= fix[0];
      out_data_r.green_out <= fix[1];
      out_data_r.red_out   <= fix[2];
      out_data_r.frame_end <= (out_row_r == h_eff - 1'b1) &&
                              (out_col_r == w_eff - 1'b1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[design/zpwm_hist_mem.sv]
`default_nettype none
module zpwm_hist_mem #(
  parameter int DEPTH = 4 * zpwm_pkg::MAX_WIDTH_DEF + 5,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [zpwm_pkg::PIX_W-1:0]  wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic      [zpwm_pkg::PIX_W-1:0]  rdata
);

  logic [zpwm_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/zpwm_div.sv]
`default_nettype none
// Three restoring dividers in lockstep, one quotient bit per cycle.
module zpwm_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire zpwm_pkg::sums_t num,
  input  wire zpwm_pkg::cnts_t den,
  output logic                 done,
  output zpwm_pkg::quos_t      quo
);

  localparam int SW = zpwm_pkg::SUM_W;
  localparam int CW = zpwm_pkg::CNT_W;
  localparam int KW = $clog2(SW);

  logic                 busy_r, busy_nxt;
  logic [KW-1:0]        cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  zpwm_pkg::sums_t      num_r, num_nxt;
  zpwm_pkg::sums_t      q_r, q_nxt;
  zpwm_pkg::cnts_t      den_r, den_nxt;
  zpwm_pkg::cnts_t      rem_r, rem_nxt;
  logic [CW:0]          trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    num_nxt  = num_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    trial    = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      for (int k = 0; k < zpwm_pkg::CH; k++) begin
        trial = {rem_r[k], num_r[k][SW-1]};
        if (trial >= {1'b0, den_r[k]}) begin
          trial = trial - {1'b0, den_r[k]};
          q_nxt[k] = {q_r[k][SW-2:0], 1'b1};
        end else begin
          q_nxt[k] = {q_r[k][SW-2:0], 1'b0};
        end
        rem_nxt[k] = trial[CW-1:0];
        num_nxt[k] = {num_r[k][SW-2:0], 1'b0};
      end
      if (cnt_r == KW'(SW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;

  always_comb begin
    for (int k = 0; k < zpwm_pkg::CH; k++) begin
      quo[k] = q_r[k][7:0];
    end
  end

endmodule
`default_nettype wire
